[design/ckdm_pkg.sv]
// Shared widths, types and the mixer round function for the card key derivation block.
package ckdm_pkg;

    localparam int KEY_W    = 32;
    localparam int SERIAL_W = 32;
    localparam int DKEY_W   = 64;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t n;
        byte_t m;
    } round_out_t;

    // m = ((a ^ b) + p) ^ q, n = (a + b + r) ^ s, all sums modulo 256
    function automatic round_out_t mix_round(byte_t a, byte_t b, byte_t p,
                                             byte_t q, byte_t r, byte_t s);
        round_out_t res;
        byte_t      sum_m;
        byte_t      sum_n;
        sum_m = (a ^ b) + p;
        sum_n = a + b + r;
        res.m = sum_m ^ q;
        res.n = sum_n ^ s;
        return res;
    endfunction

endpackage

[design/card_key_derivation_mix_top.sv]
// Card key derivation: serial word in, 64-bit derived key out, master key register.
//
// Each accepted serial word produces one 64-bit derived key. A word is taken
// into an input register, both eight-round byte mixers (one on the serial
// bytes, one on their complement) run in the logic between that register and
// the result register, so m_valid rises as the word enters the result register;
// a new word can be accepted every cycle, and throughput is one word per cycle,
// while m_ready stays high. The master key is written through cfg_we/cfg_wdata,
// resets to zero, and must only be changed while no word is in flight.
module card_key_derivation_mix_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ckdm_pkg::KEY_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ckdm_pkg::SERIAL_W-1:0] s_serial_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ckdm_pkg::DKEY_W-1:0]   m_derived_key
);

    logic [ckdm_pkg::KEY_W-1:0]    master_key_reg;
    logic                          in_valid_reg;
    logic [ckdm_pkg::SERIAL_W-1:0] in_word_reg;
    logic                          out_valid_reg;
    logic [ckdm_pkg::DKEY_W-1:0]   out_key_reg;

    logic                          out_load;
    logic [ckdm_pkg::SERIAL_W-1:0] mix_low;
    logic [ckdm_pkg::SERIAL_W-1:0] mix_high;

    // result register can take a word when empty or being drained
    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;

    ckdm_mixer u_mix_text (
        .key      (master_key_reg),
        .data_in  (in_word_reg),
        .data_out (mix_low)
    );

    ckdm_mixer u_mix_compl (
        .key      (master_key_reg),
        .data_in  (~in_word_reg),
        .data_out (mix_high)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_key_reg <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                master_key_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_serial_word;
        end
        if (out_load && in_valid_reg) begin
            out_key_reg <= {mix_high, mix_low};
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_derived_key = out_key_reg;

endmodule

[design/ckdm_mixer.sv]
// Eight-round byte mixer: four data bytes mixed under four key bytes.
module ckdm_mixer (
    input  logic [ckdm_pkg::KEY_W-1:0]    key,
    input  logic [ckdm_pkg::SERIAL_W-1:0] data_in,
    output logic [ckdm_pkg::SERIAL_W-1:0] data_out
);

    always_comb begin
        ckdm_pkg::byte_t      x0, x1, x2, x3;
        ckdm_pkg::byte_t      y0, y1, y2, y3;
        ckdm_pkg::round_out_t t;

        x0 = key[7:0];
        x1 = key[15:8];
        x2 = key[23:16];
        x3 = key[31:24];
        y0 = data_in[7:0];
        y1 = data_in[15:8];
        y2 = data_in[23:16];
        y3 = data_in[31:24];

        // pairing and write-back order are part of the scheme
        t = ckdm_pkg::mix_round(x0, x1, y2, y0, y3, y1); y0 = t.m; y1 = t.n;
        t = ckdm_pkg::mix_round(x1, x2, y0, y2, y1, y3); y2 = t.m; y3 = t.n;
        t = ckdm_pkg::mix_round(x2, x3, y1, y3, y0, y2); y2 = t.m; y3 = t.n;
        t = ckdm_pkg::mix_round(x0, x3, y2, y1, y3, y0); y0 = t.m; y1 = t.n;
        t = ckdm_pkg::mix_round(x0, x3, y3, y1, y2, y0); y0 = t.m; y1 = t.n;
        t = ckdm_pkg::mix_round(x2, x3, y0, y3, y1, y2); y2 = t.m; y3 = t.n;
        t = ckdm_pkg::mix_round(x1, x2, y1, y3, y0, y2); y2 = t.m; y3 = t.n;
        t = ckdm_pkg::mix_round(x0, x1, y2, y1, y3, y0); y0 = t.m; y1 = t.n;

        data_out = {y3, y2, y1, y0};
    end

endmodule

[design/ckdm_checker.sv]
// Port-level checks for the card key derivation top level, bound to it.
module ckdm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [ckdm_pkg::DKEY_W-1:0]   m_derived_key
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_derived_key))
        else $error("stalled result word changed");

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // result valid is raised only after an input word was taken, via the input and result registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input word");

    // with the result stage empty the block must take input
    assert property (@(posedge aclk) !m_valid |-> s_ready)
        else $error("input stalled while output empty");

endmodule

bind card_key_derivation_mix_top ckdm_checker u_ckdm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_derived_key (m_derived_key)
);

[dv/card_key_derivation_mix_top_tb.sv]
// Testbench for the card key derivation block: self-checking against its own key mixer.
`timescale 1ns / 1ps

module card_key_derivation_mix_top_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int WORDS_A_PHASE = 225;
    localparam int RANDOM_PHASES = 6;

    // holds the master key copy and the derived keys still owed by the block
    class derived_key_ledger;
        logic [ckdm_pkg::KEY_W-1:0]  master_key;
        logic [ckdm_pkg::DKEY_W-1:0] expected_keys[$];
        int                          mismatches;

        function new();
            master_key = '0;
            mismatches = 0;
        endfunction

        function void load_key(logic [ckdm_pkg::KEY_W-1:0] k);
            master_key = k;
        endfunction

        // {n, m}: m = ((a ^ b) + p) ^ q, n = (a + b + r) ^ s, sums wrap at 8 bits
        function logic [15:0] mix_pair(ckdm_pkg::byte_t a, ckdm_pkg::byte_t b,
                                       ckdm_pkg::byte_t p, ckdm_pkg::byte_t q,
                                       ckdm_pkg::byte_t r, ckdm_pkg::byte_t s);
            ckdm_pkg::byte_t sum_m;
            ckdm_pkg::byte_t sum_n;
            sum_m = (a ^ b) + p;
            sum_n = a + b + r;
            return {sum_n ^ s, sum_m ^ q};
        endfunction

        function logic [31:0] mix_rounds(logic [31:0] data);
            ckdm_pkg::byte_t x0, x1, x2, x3;
            ckdm_pkg::byte_t y0, y1, y2, y3;
            {x3, x2, x1, x0} = master_key;
            {y3, y2, y1, y0} = data;
            {y1, y0} = mix_pair(x0, x1, y2, y0, y3, y1);
            {y3, y2} = mix_pair(x1, x2, y0, y2, y1, y3);
            {y3, y2} = mix_pair(x2, x3, y1, y3, y0, y2);
            {y1, y0} = mix_pair(x0, x3, y2, y1, y3, y0);
            {y1, y0} = mix_pair(x0, x3, y3, y1, y2, y0);
            {y3, y2} = mix_pair(x2, x3, y0, y3, y1, y2);
            {y3, y2} = mix_pair(x1, x2, y1, y3, y0, y2);
            {y1, y0} = mix_pair(x0, x1, y2, y1, y3, y0);
            return {y3, y2, y1, y0};
        endfunction

        function void note_serial(logic [ckdm_pkg::SERIAL_W-1:0] w);
            expected_keys.push_back({mix_rounds(~w), mix_rounds(w)});
        endfunction

        function void check_derived(logic [ckdm_pkg::DKEY_W-1:0] got);
            logic [ckdm_pkg::DKEY_W-1:0] want;
            if (expected_keys.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected derived key %h, nothing pending", got);
                return;
            end
            want = expected_keys.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("derived key mismatch: expected %h, got %h", want, got);
            end
        endfunction

        function int pending();
            return expected_keys.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [ckdm_pkg::KEY_W-1:0]    cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic [ckdm_pkg::SERIAL_W-1:0] s_serial_word;
    logic                          m_valid;
    logic                          m_ready;
    logic [ckdm_pkg::DKEY_W-1:0]   m_derived_key;

    derived_key_ledger ledger = new();
    int                idle_pct  = 0;
    int                stall_pct = 0;
    int                cycle_count = 0;

    card_key_derivation_mix_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_serial_word (s_serial_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_derived_key (m_derived_key)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stall bursts while stall_pct is non-zero
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            ledger.check_derived(m_derived_key);
    end

    task automatic write_key(input logic [ckdm_pkg::KEY_W-1:0] k);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge aclk);
        cfg_we <= 1'b0;
        ledger.load_key(k);
    endtask

    // one word; gap idles the sender first, drain holds off until all results are back
    task automatic push_serial(input logic [ckdm_pkg::SERIAL_W-1:0] w, input int gap,
                               input bit drain);
        if (drain && gap == 0)
            gap = 1;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            while (drain && ledger.pending() != 0) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_serial_word <= w;
        do @(posedge aclk); while (!s_ready);
        ledger.note_serial(w);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic int pick_gap();
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            return $urandom_range(1, 13);
        return 0;
    endfunction

    function automatic logic [ckdm_pkg::SERIAL_W-1:0] pick_serial();
        logic [ckdm_pkg::SERIAL_W-1:0] w;
        w = $urandom;
        case ($urandom_range(0, 15))
            0: w = '0;
            1: w = '1;
            2: w = 32'hFF << (8 * $urandom_range(0, 3));
            3: w = 32'h1 << $urandom_range(0, 31);
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        logic [ckdm_pkg::SERIAL_W-1:0] corner_words[8];
        logic [ckdm_pkg::KEY_W-1:0]    phase_key;
        int                            ph;
        int                            i;

        corner_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                         32'h5555_5555, 32'hAAAA_AAAA, 32'h7F7F_7F7F, 32'h0123_4567};
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_serial_word <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset key, then an all-ones key (every a + b sum wraps), then mixed bytes
        for (i = 0; i < 6; i++) push_serial(corner_words[i], 0, 1'b0);
        settle();
        write_key(32'hFFFF_FFFF);
        for (i = 0; i < 8; i++) push_serial(corner_words[i], 0, 1'b0);
        push_serial(32'h00FF_00FF, 0, 1'b0);
        push_serial(32'hFF00_FF00, 0, 1'b0);
        settle();
        write_key(32'h7F80_FF01);
        for (i = 0; i < 6; i++) push_serial(corner_words[i], 0, 1'b0);
        settle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: phase_key = '0;
                1: phase_key = '1;
                2: phase_key = 32'h8000_0001;
                default: phase_key = $urandom;
            endcase
            write_key(phase_key);
            if (ph == RANDOM_PHASES - 1) begin
                idle_pct  = 0;
                stall_pct = 0;
            end else begin
                idle_pct  = (ph % 3 == 0) ? 30 : (ph % 3 == 1) ? 5 : 0;
                stall_pct = (ph % 3 == 2) ? 30 : (ph % 3 == 0) ? 8 : 0;
            end
            for (i = 0; i < WORDS_A_PHASE; i++)
                push_serial(pick_serial(), pick_gap(),
                            (ph == 1 && i == WORDS_A_PHASE / 2));
            settle();
        end

        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
